### sv/i2cseq_pkg.sv
// Package with the command codes, sequencer state type and slot count table.
`default_nettype none

package i2cseq_pkg;

  localparam int unsigned FuncW  = 3;
  localparam int unsigned SlotW  = 5;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BitIdxW = 3;
  localparam int unsigned PhaseW = 2;

  // Command codes. Code zero is both the tick function and the idle state.
  typedef enum logic [FuncW-1:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_SACK  = 3'd5,
    CMD_RACK  = 3'd6
  } cmd_e;

  // Bit phase. Write: set SDA, raise, drop SCL. Read: raise, sample, drop.
  typedef enum logic [PhaseW-1:0] {
    PH_SETUP = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2
  } phase_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [SlotW-1:0]   slot;
    logic [BitIdxW-1:0] bit_idx;
    phase_e             phase;
    logic [ByteW-1:0]   shift;
    logic               scl;
    logic               sda;
    logic               ack_seen;
    logic [ByteW-1:0]   rx_byte;
  } seq_state_t;

  typedef struct packed {
    logic done;
    logic rejected;
  } step_flags_t;

  function automatic logic [SlotW-1:0] slot_total(input cmd_e cmd);
    logic [SlotW-1:0] total;
    case (cmd)
      CMD_START: total = 5'd4;
      CMD_STOP:  total = 5'd3;
      CMD_WRITE: total = 5'd24;
      CMD_READ:  total = 5'd25;
      CMD_SACK:  total = 5'd3;
      CMD_RACK:  total = 5'd4;
      default:   total = 5'd0;
    endcase
    return total;
  endfunction

endpackage

`default_nettype wire

### sv/i2cseq_step.sv
// Next-state logic of the line sequencer for one request.
`default_nettype none

module i2cseq_step (
  input  i2cseq_pkg::seq_state_t  cur_i,
  input  logic [2:0]              func_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    ack_out_i,
  input  logic                    sda_in_i,
  output i2cseq_pkg::seq_state_t  nxt_o,
  output i2cseq_pkg::step_flags_t flags_o
);
  import i2cseq_pkg::*;

  logic             is_cmd;
  logic [SlotW-1:0] slot_inc;
  logic             counted;

  assign is_cmd   = func_i inside {[CMD_START:CMD_RACK]};
  assign slot_inc = cur_i.slot + 5'd1;

  always_comb begin
    nxt_o   = cur_i;
    flags_o = '0;
    counted = 1'b0;
    if (is_cmd) begin
      if (cur_i.cmd != CMD_IDLE) begin
        flags_o.rejected = 1'b1;
      end else begin
        nxt_o.cmd     = cmd_e'(func_i);
        nxt_o.slot    = '0;
        nxt_o.bit_idx = '0;
        nxt_o.phase   = PH_SETUP;
        case (cmd_e'(func_i))
          CMD_WRITE: nxt_o.shift = data_byte_i;
          CMD_SACK:  nxt_o.shift = {7'd0, ack_out_i};
          default:   nxt_o.shift = '0;
        endcase
      end
    end else if (cur_i.cmd != CMD_IDLE) begin
      case (cur_i.cmd)
        CMD_START: begin
          case (cur_i.slot)
            5'd0:    nxt_o.sda = 1'b1;
            5'd1:    nxt_o.scl = 1'b1;
            5'd2:    nxt_o.sda = 1'b0;
            default: nxt_o.scl = 1'b0;
          endcase
        end
        CMD_STOP: begin
          case (cur_i.slot)
            5'd0:    nxt_o.sda = 1'b0;
            5'd1:    nxt_o.scl = 1'b1;
            default: nxt_o.sda = 1'b1;
          endcase
        end
        CMD_WRITE: begin
          counted = 1'b1;
          case (cur_i.phase)
            PH_SETUP: nxt_o.sda = cur_i.shift[~cur_i.bit_idx];
            PH_HIGH:  nxt_o.scl = 1'b1;
            default:  nxt_o.scl = 1'b0;
          endcase
        end
        CMD_READ: begin
          // The first slot releases SDA; the bit phases follow it.
          if (cur_i.slot == '0) begin
            nxt_o.sda = 1'b1;
          end else begin
            counted = 1'b1;
            case (cur_i.phase)
              PH_SETUP: nxt_o.scl = 1'b1;
              PH_HIGH: begin
                if (sda_in_i) begin
                  nxt_o.shift[~cur_i.bit_idx] = 1'b1;
                end
              end
              default: nxt_o.scl = 1'b0;
            endcase
          end
        end
        CMD_SACK: begin
          case (cur_i.slot)
            5'd0:    nxt_o.sda = cur_i.shift[0];
            5'd1:    nxt_o.scl = 1'b1;
            default: nxt_o.scl = 1'b0;
          endcase
        end
        CMD_RACK: begin
          case (cur_i.slot)
            5'd0:    nxt_o.sda = 1'b1;
            5'd1:    nxt_o.scl = 1'b1;
            5'd2:    nxt_o.ack_seen = sda_in_i;
            default: nxt_o.scl = 1'b0;
          endcase
        end
        default: ;
      endcase

      if (counted) begin
        if (cur_i.phase == PH_LOW) begin
          nxt_o.phase   = PH_SETUP;
          nxt_o.bit_idx = cur_i.bit_idx + 3'd1;
        end else begin
          nxt_o.phase = phase_e'(cur_i.phase + 2'd1);
        end
      end

      if (slot_inc >= slot_total(cur_i.cmd)) begin
        if (cur_i.cmd == CMD_READ) begin
          nxt_o.rx_byte = nxt_o.shift;
        end
        flags_o.done = 1'b1;
        nxt_o.cmd    = CMD_IDLE;
        nxt_o.slot   = '0;
      end else begin
        nxt_o.slot = slot_inc;
      end
    end
  end

endmodule

`default_nettype wire

### sv/i2c_master_bit_sequencer_unit.sv
// Top level of the I2C master line sequencer with its stream ports.
//
// Usage: each request on the slave stream is either a command (start, stop,
// write byte, read byte, send ack, receive ack) or a tick. A command is taken
// only while the sequencer is idle; one that arrives while busy is ignored and
// its result reports rejected. Each tick performs one pin slot of the running
// command, standing for one bus delay period; the caller sends ticks at the
// bus timing it wants and feeds the sampled SDA level with each tick.
// Every request produces exactly one result on the master stream carrying the
// SCL and SDA levels after that request, busy, done, rejected, the last read
// byte and the last sampled ack bit.
// Results: the result of a request is registered and valid the cycle after it is accepted.
// Throughput: one request per cycle while the receiver keeps up; the sequencer
// state and the result register are both updated in the accepting cycle, so
// apart from stalls only the state register loop sets the pace.
// Stalls: the result register holds its value while the receiver keeps
// m_axis_tready_i low; the slave side stays ready as long as the result
// register is empty or being drained in the same cycle.
// Reset: the sequencer is idle with both lines released high, the read byte
// and ack bit are zero, and no result is pending.
`default_nettype none

module i2c_master_bit_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] data_byte, [8] ack_out, [9] sda_in, [15:10] zero
  input  logic [15:0] s_axis_tdata_i,
  // [2:0] func
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] scl, [1] sda, [2] busy_res, [3] done_res, [4] rejected,
  // [12:5] read_byte, [13] ack_in, [15:14] zero
  output logic [15:0] m_axis_tdata_o
);
  import i2cseq_pkg::*;

  seq_state_t  state_q, state_d;
  step_flags_t flags;
  logic        out_valid_q;
  logic [15:0] out_data_q, out_data_d;
  logic        in_accept;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  i2cseq_step u_step (
    .cur_i       (state_q),
    .func_i      (s_axis_tuser_i),
    .data_byte_i (s_axis_tdata_i[7:0]),
    .ack_out_i   (s_axis_tdata_i[8]),
    .sda_in_i    (s_axis_tdata_i[9]),
    .nxt_o       (state_d),
    .flags_o     (flags)
  );

  // The result reports the levels and status after this request.
  assign out_data_d = {2'b00,
                       state_d.ack_seen,
                       state_d.rx_byte,
                       flags.rejected,
                       flags.done,
                       (state_d.cmd != CMD_IDLE),
                       state_d.sda,
                       state_d.scl};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{cmd: CMD_IDLE, slot: '0, bit_idx: '0, phase: PH_SETUP,
                   shift: '0, scl: 1'b1, sda: 1'b1, ack_seen: 1'b0,
                   rx_byte: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

### sv/i2cseq_checker.sv
// Port-level checker for the line sequencer, bound to the top level.
`default_nettype none

module i2cseq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // A finished command is no longer busy.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[3] |-> !m_axis_tdata_o[2])
    else $error("done reported while still busy");

  // A rejected command means another one is still running.
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[4] |-> m_axis_tdata_o[2] && !m_axis_tdata_o[3])
    else $error("rejected request without a running command");

  // The slave side only stalls while a result waits for the receiver.
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled with no pending result");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

endmodule

bind i2c_master_bit_sequencer_unit i2cseq_checker u_i2cseq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
